>>> design/clpr_pkg.sv
`default_nettype none

package clpr_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 24;
  localparam int COORD_W  = 12;
  localparam int TRIG_W   = 18;
  localparam int TRIG_FRAC = TRIG_W - 2;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS_SELECT = 1'b1;

  // Axis codes
  localparam int AXIS_W = 2;
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // CORDIC on a 32-bit turn angle, unit gain at 2^30
  localparam int TURN_W          = 32;
  localparam int TURN_PAD        = TURN_W - PHASE_W;
  localparam int CORDIC_STEPS    = 20;
  localparam int CORDIC_ONE_BITS = 30;
  localparam int CORDIC_W        = 33;
  localparam int CORDIC_GAIN_INV = 652032874;
  localparam int TRIG_DROP       = CORDIC_ONE_BITS - TRIG_FRAC;
  localparam int TRIG_ONE        = 1 << TRIG_FRAC;

  // Complex product
  localparam int PROD_W = SAMPLE_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_real;
    logic signed [SAMPLE_W-1:0] sample_imag;
    logic [COORD_W-1:0]         coord_x;
    logic [COORD_W-1:0]         coord_y;
    logic [COORD_W-1:0]         coord_z;
  } voxel_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] result_real;
    logic signed [SAMPLE_W-1:0] result_imag;
  } result_t;

  // Voxel value carried along the pipeline
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } cplx_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [CORDIC_W-1:0] atan_turn(input int step);
    logic signed [CORDIC_W-1:0] a;
    case (step)
      0:  a = 33'sd536870912;
      1:  a = 33'sd316933406;
      2:  a = 33'sd167458907;
      3:  a = 33'sd85005268;
      4:  a = 33'sd42667331;
      5:  a = 33'sd21354465;
      6:  a = 33'sd10680862;
      7:  a = 33'sd5340245;
      8:  a = 33'sd2670163;
      9:  a = 33'sd1335087;
      10: a = 33'sd667544;
      11: a = 33'sd333772;
      12: a = 33'sd166886;
      13: a = 33'sd83443;
      14: a = 33'sd41722;
      15: a = 33'sd20861;
      16: a = 33'sd10430;
      17: a = 33'sd5215;
      18: a = 33'sd2608;
      19: a = 33'sd1304;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> design/clpr_phase.sv
`default_nettype none

module clpr_phase (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                valid_in,
  input  wire clpr_pkg::voxel_t                    voxel,
  input  wire logic [clpr_pkg::PHASE_W-1:0]        phase_step,
  input  wire logic [clpr_pkg::AXIS_W-1:0]         axis_select,
  output logic                                     valid,
  output logic [clpr_pkg::PHASE_W-1:0]             phase,
  output clpr_pkg::cplx_t                          samp
);

  logic [clpr_pkg::COORD_W-1:0]                    coord;
  logic [clpr_pkg::PHASE_W+clpr_pkg::COORD_W-1:0]  prod;

  // Pick the coordinate on the chosen axis; the unused code gives phase zero
  always_comb begin
    case (axis_select)
      clpr_pkg::AXIS_X: coord = voxel.coord_x;
      clpr_pkg::AXIS_Y: coord = voxel.coord_y;
      clpr_pkg::AXIS_Z: coord = voxel.coord_z;
      default:          coord = '0;
    endcase
  end

  assign prod = phase_step * coord;

  // Hold the item while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      phase   <= prod[clpr_pkg::PHASE_W-1:0];
      samp.re <= voxel.sample_real;
      samp.im <= voxel.sample_imag;
    end
  end

  a_zero_step: assert property (@(posedge clk) disable iff (rst)
    $past(en) && ($past(phase_step) == '0) |-> phase == '0)
    else $error("nonzero phase from zero phase step");

endmodule

`default_nettype wire

>>> design/clpr_cordic.sv
`default_nettype none

module clpr_cordic (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire logic                                  valid_in,
  input  wire logic [clpr_pkg::PHASE_W-1:0]          phase,
  input  wire clpr_pkg::cplx_t                       samp_in,
  output logic                                       valid,
  output logic signed [clpr_pkg::CORDIC_W-1:0]       x_out,
  output logic signed [clpr_pkg::CORDIC_W-1:0]       y_out,
  output logic [1:0]                                 quad,
  output clpr_pkg::cplx_t                            samp
);

  localparam int N = clpr_pkg::CORDIC_STEPS;
  localparam int W = clpr_pkg::CORDIC_W;

  logic signed [W-1:0] x_st [0:N];
  logic signed [W-1:0] y_st [0:N];
  logic signed [W-1:0] z_st [0:N];
  logic [1:0]          q_st [0:N];
  clpr_pkg::cplx_t     s_st [0:N];
  logic                v_st [0:N];

  // Seed: quadrant from the top two bits, residual angle inside it
  assign x_st[0] = W'(clpr_pkg::CORDIC_GAIN_INV);
  assign y_st[0] = '0;
  assign z_st[0] = {{(W - clpr_pkg::TURN_W + 2){1'b0}},
                    phase[clpr_pkg::PHASE_W-3:0],
                    {clpr_pkg::TURN_PAD{1'b0}}};
  assign q_st[0] = phase[clpr_pkg::PHASE_W-1 -: 2];
  assign s_st[0] = samp_in;
  assign v_st[0] = valid_in;

  // One rotation per register stage
  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic                up;

    assign dx = y_st[i] >>> i;
    assign dy = x_st[i] >>> i;
    assign up = !z_st[i][W-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v_st[i+1] <= 1'b0;
      end else if (en) begin
        v_st[i+1] <= v_st[i];
      end
      if (en) begin
        if (up) begin
          x_st[i+1] <= x_st[i] - dx;
          y_st[i+1] <= y_st[i] + dy;
          z_st[i+1] <= z_st[i] - clpr_pkg::atan_turn(i);
        end else begin
          x_st[i+1] <= x_st[i] + dx;
          y_st[i+1] <= y_st[i] - dy;
          z_st[i+1] <= z_st[i] + clpr_pkg::atan_turn(i);
        end
        q_st[i+1] <= q_st[i];
        s_st[i+1] <= s_st[i];
      end
    end
  end

  assign valid = v_st[N];
  assign x_out = x_st[N];
  assign y_out = y_st[N];
  assign quad  = q_st[N];
  assign samp  = s_st[N];

  a_converged: assert property (@(posedge clk) disable iff (rst)
    v_st[N] |-> (z_st[N] <= 33'sd4096) && (z_st[N] >= -33'sd4096))
    else $error("residual angle did not converge");

endmodule

`default_nettype wire

>>> design/clpr_mix.sv
`default_nettype none

module clpr_mix (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire logic                                  valid_in,
  input  wire logic signed [clpr_pkg::CORDIC_W-1:0]  x_in,
  input  wire logic signed [clpr_pkg::CORDIC_W-1:0]  y_in,
  input  wire logic [1:0]                            quad,
  input  wire clpr_pkg::cplx_t                       samp_in,
  output logic                                       valid,
  output clpr_pkg::result_t                          result
);

  localparam int W  = clpr_pkg::CORDIC_W;
  localparam int TW = clpr_pkg::TRIG_W;
  localparam int PW = clpr_pkg::PROD_W;
  localparam int SW = clpr_pkg::SUM_W;
  localparam logic signed [W:0]    TRIG_HALF = (W+1)'(1) <<< (clpr_pkg::TRIG_DROP - 1);
  localparam logic signed [W:0]    ONE_W     = (W+1)'(clpr_pkg::TRIG_ONE);
  localparam logic signed [TW-1:0] ONE_T     = TW'(clpr_pkg::TRIG_ONE);
  localparam logic signed [SW-1:0] PROD_HALF = SW'(1) <<< (clpr_pkg::TRIG_FRAC - 1);
  localparam logic signed [SW-1:0] SMAX = SW'((1 << (clpr_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

  logic signed [W-1:0]  xq;
  logic signed [W-1:0]  yq;
  logic signed [W:0]    xr;
  logic signed [W:0]    yr;

  logic                 rot_valid;
  logic signed [TW-1:0] cs;
  logic signed [TW-1:0] sn;
  clpr_pkg::cplx_t      rot_samp;

  logic                 prod_valid;
  logic signed [PW-1:0] p_ac;
  logic signed [PW-1:0] p_bs;
  logic signed [PW-1:0] p_as;
  logic signed [PW-1:0] p_bc;

  logic signed [SW-1:0] sum_re;
  logic signed [SW-1:0] sum_im;

  function automatic logic signed [TW-1:0] clamp_trig(input logic signed [W:0] v);
    logic signed [TW-1:0] r;
    if (v > ONE_W) begin
      r = ONE_T;
    end else if (v < -ONE_W) begin
      r = -ONE_T;
    end else begin
      r = v[TW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [clpr_pkg::SAMPLE_W-1:0] clamp_sample(
    input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SMAX) begin
      r = SMAX;
    end else if (v < SMIN) begin
      r = SMIN;
    end else begin
      r = v;
    end
    return r[clpr_pkg::SAMPLE_W-1:0];
  endfunction

  // Unfold the quadrant, then round to the trig format
  always_comb begin
    case (quad)
      2'd1:    begin xq = -y_in; yq = x_in;  end
      2'd2:    begin xq = -x_in; yq = -y_in; end
      2'd3:    begin xq = y_in;  yq = -x_in; end
      default: begin xq = x_in;  yq = y_in;  end
    endcase
    xr = ((W+1)'(xq) + TRIG_HALF) >>> clpr_pkg::TRIG_DROP;
    yr = ((W+1)'(yq) + TRIG_HALF) >>> clpr_pkg::TRIG_DROP;
  end

  // Combine the products with round to nearest
  always_comb begin
    sum_re = (SW'(p_ac) - SW'(p_bs) + PROD_HALF) >>> clpr_pkg::TRIG_FRAC;
    sum_im = (SW'(p_as) + SW'(p_bc) + PROD_HALF) >>> clpr_pkg::TRIG_FRAC;
  end

  // Advance all three stages together; hold on stall
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_valid  <= 1'b0;
      prod_valid <= 1'b0;
      valid      <= 1'b0;
    end else if (en) begin
      rot_valid  <= valid_in;
      prod_valid <= rot_valid;
      valid      <= prod_valid;
    end
    if (en) begin
      cs       <= clamp_trig(xr);
      sn       <= clamp_trig(yr);
      rot_samp <= samp_in;
      p_ac     <= rot_samp.re * cs;
      p_bs     <= rot_samp.im * sn;
      p_as     <= rot_samp.re * sn;
      p_bc     <= rot_samp.im * cs;
      result.result_real <= clamp_sample(sum_re);
      result.result_imag <= clamp_sample(sum_im);
    end
  end

  a_trig_range: assert property (@(posedge clk) disable iff (rst)
    rot_valid |-> (cs <= ONE_T) && (cs >= -ONE_T) && (sn <= ONE_T) && (sn >= -ONE_T))
    else $error("phasor outside unit range");

endmodule

`default_nettype wire

>>> design/complex_linear_phase_ramp_core.sv
// Linear phase ramp: each item (a complex Q1.15 voxel and its x, y, z
// indices) leaves multiplied by exp(j*2*pi*phase_step*coord/2^24), coord being
// the index on the axis picked by axis_select; results are rounded and
// saturated. One item is taken every cycle unless the pipeline is stalled.
// Its stages: one for the phase multiply, twenty CORDIC rotation stages, one
// stage for quadrant unfold and rounding of cos/sin, one for the four products
// and one for the sums into the output register. A stalled result freezes the
// whole pipeline, so sample_stall follows result_valid and result_stall in the
// same cycle. Write configuration only while no item is in flight.
`default_nettype none

module complex_linear_phase_ramp_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [clpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [clpr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                sample_valid,
  output logic                                     sample_stall,
  input  wire clpr_pkg::voxel_t                    sample,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output clpr_pkg::result_t                        result
);

  logic [clpr_pkg::PHASE_W-1:0]               phase_step;
  logic [clpr_pkg::AXIS_W-1:0]                axis_select;
  logic                                       en;

  logic                                       ph_valid;
  logic [clpr_pkg::PHASE_W-1:0]               ph_phase;
  clpr_pkg::cplx_t                            ph_samp;

  logic                                       cr_valid;
  logic signed [clpr_pkg::CORDIC_W-1:0]       cr_x;
  logic signed [clpr_pkg::CORDIC_W-1:0]       cr_y;
  logic [1:0]                                 cr_quad;
  clpr_pkg::cplx_t                            cr_samp;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= '0;
      axis_select <= clpr_pkg::AXIS_X;
    end else if (cfg_we) begin
      case (cfg_index)
        clpr_pkg::REG_PHASE_STEP:  phase_step  <= cfg_data[clpr_pkg::PHASE_W-1:0];
        clpr_pkg::REG_AXIS_SELECT: axis_select <= cfg_data[clpr_pkg::AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless a finished item is held
  assign en           = !(result_valid && result_stall);
  assign sample_stall = !en;

  clpr_phase u_phase (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .valid_in    (sample_valid),
    .voxel       (sample),
    .phase_step  (phase_step),
    .axis_select (axis_select),
    .valid       (ph_valid),
    .phase       (ph_phase),
    .samp        (ph_samp)
  );

  clpr_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (ph_valid),
    .phase    (ph_phase),
    .samp_in  (ph_samp),
    .valid    (cr_valid),
    .x_out    (cr_x),
    .y_out    (cr_y),
    .quad     (cr_quad),
    .samp     (cr_samp)
  );

  clpr_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (cr_valid),
    .x_in     (cr_x),
    .y_in     (cr_y),
    .quad     (cr_quad),
    .samp_in  (cr_samp),
    .valid    (result_valid),
    .result   (result)
  );

endmodule

`default_nettype wire

>>> sim/tb_complex_linear_phase_ramp_core.sv
`timescale 1ns / 100ps

module tb_complex_linear_phase_ramp_core;
  import clpr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 48;
  localparam int MAX_PRINTED = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  voxel_t sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  // Shadow copy of the configuration registers
  logic [PHASE_W-1:0] cur_step = '0;
  logic [AXIS_W-1:0] cur_axis = AXIS_X;

  voxel_t pending_voxels[$];
  result_t expected_rotations[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // atan(2^-i) in units of 2^-32 turn
  longint atan_table[CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85005268, 42667331,
    21354465, 10680862, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304
  };

  complex_linear_phase_ramp_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Rotate one voxel by the phase ramp value at its coordinate
  function automatic result_t rotate_voxel(input voxel_t v, input logic [PHASE_W-1:0] step,
                                           input logic [AXIS_W-1:0] axis);
    logic [COORD_W-1:0] coord;
    logic [PHASE_W+COORD_W-1:0] prod;
    logic [TURN_W-1:0] turn;
    longint x, y, z, t, dx, dy, c, s, a, b, re, im;
    longint one, smax, smin;
    result_t r;
    case (axis)
      AXIS_X: coord = v.coord_x;
      AXIS_Y: coord = v.coord_y;
      AXIS_Z: coord = v.coord_z;
      default: coord = '0;
    endcase
    prod = step * coord;
    turn = {prod[PHASE_W-1:0], {TURN_PAD{1'b0}}};
    x = CORDIC_GAIN_INV;
    y = 0;
    z = longint'(turn[CORDIC_ONE_BITS-1:0]);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_table[i];
      end else begin
        x += dx; y -= dy; z += atan_table[i];
      end
    end
    // Unfold the quadrant
    case (turn[TURN_W-1 -: 2])
      2'd1: begin t = x; x = -y; y = t; end
      2'd2: begin x = -x; y = -y; end
      2'd3: begin t = x; x = y; y = -t; end
      default: ;
    endcase
    one = longint'(1) << TRIG_FRAC;
    c = clamp((x + (longint'(1) << (TRIG_DROP - 1))) >>> TRIG_DROP, -one, one);
    s = clamp((y + (longint'(1) << (TRIG_DROP - 1))) >>> TRIG_DROP, -one, one);
    a = longint'($signed(v.sample_real));
    b = longint'($signed(v.sample_imag));
    re = (a * c - b * s + (longint'(1) << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    im = (a * s + b * c + (longint'(1) << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    smax = (longint'(1) << (SAMPLE_W - 1)) - 1;
    smin = -smax - 1;
    r.result_real = SAMPLE_W'(clamp(re, smin, smax));
    r.result_imag = SAMPLE_W'(clamp(im, smin, smax));
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED)
      $display("ERROR at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Present queued items, predict each accepted one
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall)
        expected_rotations.push_back(rotate_voxel(sample, cur_step, cur_axis));
      if (!sample_valid || !sample_stall) begin
        if (pending_voxels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample <= pending_voxels.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Check accepted results against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_rotations.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", result));
        end else begin
          want = expected_rotations.pop_front();
          if (result.result_real !== want.result_real)
            report_mismatch($sformatf("result_real %0d, expected %0d",
                                      $signed(result.result_real), $signed(want.result_real)));
          if (result.result_imag !== want.result_imag)
            report_mismatch($sformatf("result_imag %0d, expected %0d",
                                      $signed(result.result_imag), $signed(want.result_imag)));
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_PHASE_STEP)
      cur_step = data[PHASE_W-1:0];
    else
      cur_axis = data[AXIS_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until no item is queued, presented or in flight
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_voxels.size() != 0 || sample_valid || expected_rotations.size() != 0);
  endtask

  task automatic push_voxel(input int re, input int im, input int x, input int y, input int z);
    voxel_t v;
    v.sample_real = SAMPLE_W'(re);
    v.sample_imag = SAMPLE_W'(im);
    v.coord_x = COORD_W'(x);
    v.coord_y = COORD_W'(y);
    v.coord_z = COORD_W'(z);
    pending_voxels.push_back(v);
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(7))
      0: return {1'b1, {(SAMPLE_W-1){1'b0}}};
      1: return {1'b0, {(SAMPLE_W-1){1'b1}}};
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] random_coord();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return COORD_W'($urandom());
    endcase
  endfunction

  function automatic voxel_t random_voxel();
    voxel_t v;
    v.sample_real = random_sample();
    v.sample_imag = random_sample();
    v.coord_x = random_coord();
    v.coord_y = random_coord();
    v.coord_z = random_coord();
    return v;
  endfunction

  initial begin
    logic [PHASE_W-1:0] steps[8];
    logic [CFG_DATA_W-1:0] axis_word;
    steps = '{24'hFFFFFF, 24'h000001, 24'h0, 24'h800000, 24'h0, 24'h000000, 24'h0, 24'h123457};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Quarter turn per x step, junk in the high axis bits
    write_reg(REG_PHASE_STEP, 24'h400000);
    write_reg(REG_AXIS_SELECT, {22'h3FFFFF, AXIS_X});
    push_voxel(32767, 0, 0, 4095, 4095);
    push_voxel(-32768, -32768, 1, 0, 0);
    push_voxel(-32768, 0, 2, 17, 99);
    push_voxel(0, -32768, 2, 5, 5);
    push_voxel(32767, 32767, 3, 4095, 0);
    push_voxel(-32768, 32767, 4095, 1, 2);
    wait_idle();

    // Largest step on y
    write_reg(REG_PHASE_STEP, 24'hFFFFFF);
    write_reg(REG_AXIS_SELECT, {22'h0, AXIS_Y});
    push_voxel(32767, -32768, 4095, 0, 4095);
    push_voxel(-32768, -32768, 0, 1, 0);
    push_voxel(12345, -2345, 0, 4095, 0);
    push_voxel(-1, 1, 0, 2048, 0);
    push_voxel(32767, 32767, 7, 1024, 9);
    wait_idle();

    // Third of a turn on z
    write_reg(REG_PHASE_STEP, 24'h555555);
    write_reg(REG_AXIS_SELECT, {22'h0, AXIS_Z});
    push_voxel(32767, 0, 0, 0, 1);
    push_voxel(-32768, 32767, 0, 0, 2);
    push_voxel(20000, -20000, 4095, 4095, 4095);
    push_voxel(-32768, -32768, 1, 1, 3);
    wait_idle();

    // Unused axis code: voxel passes through
    write_reg(REG_PHASE_STEP, 24'h123456);
    write_reg(REG_AXIS_SELECT, {22'h155555, 2'd3});
    push_voxel(-32768, 32767, 4095, 4095, 4095);
    push_voxel(1, -1, 123, 456, 789);
    push_voxel(32767, -32768, 1, 2, 3);
    wait_idle();

    // Eight passes with fixed or random phase steps; axis and idling pattern cycle by pass
    for (int p = 0; p < 8; p++) begin
      axis_word = {{(CFG_DATA_W-AXIS_W){1'b0}}, AXIS_W'(p % 4)};
      if (steps[p] == 24'h0 && p != 5)
        steps[p] = PHASE_W'($urandom());
      write_reg(REG_PHASE_STEP, steps[p]);
      write_reg(REG_AXIS_SELECT, axis_word | (CFG_DATA_W'($urandom()) << AXIS_W));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int n = 0; n < 240; n++)
        pending_voxels.push_back(random_voxel());
      wait_idle();
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
design/clpr_pkg.sv
design/clpr_phase.sv
design/clpr_cordic.sv
design/clpr_mix.sv
design/complex_linear_phase_ramp_core.sv
sim/tb_complex_linear_phase_ramp_core.sv
